// ===== hw/rtl/sine_tone_burst_generator_core_defines.svh =====
// Assertion macros shared by the tone burst generator RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SINE_TONE_BURST_GENERATOR_CORE_DEFINES_SVH
`define SINE_TONE_BURST_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define STBG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stbg: same-cycle check failed");

// Next-cycle implication.
`define STBG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stbg: next-cycle check failed");

`endif

// ===== hw/rtl/stbg_pkg.sv =====
// Shared constants, types and the sine table function of the tone burst generator.
// No dependencies.
`default_nettype none

package stbg_pkg;

  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF     = 16;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned ENV_W   = 17;   // Q1.16 envelope, up to 1.0
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Restoring divider produces one quotient bit per step below the integer bit.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd4;

  // Register reset values
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd21426141;
  localparam logic [LEN_W-1:0]   BURST_LEN_RST   = 16'd5292;
  localparam logic [LEN_W-1:0]   ATTACK_LEN_RST  = 16'd441;
  localparam logic [LEN_W-1:0]   RELEASE_LEN_RST = 16'd882;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 15'd11469;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef struct packed {
    logic start;     // request accepted: capture index and phase
    logic setup;     // envelope mode, divider load, table read, state update
    logic div_step;  // one restoring division step
    logic mul_amp;   // table value times amplitude
    logic mul_env;   // times envelope
    logic finish;    // round, sign, load output register
  } stbg_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic out_free;
  } stbg_sts_t;

  // Quarter-wave sine magnitude for offset r; evaluated at elaboration only.
  function automatic logic [AMP_W-1:0] quarter_sine(int unsigned addr_bits, int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] v;
    x  = (64'(r) * TWO_PI_Q30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = x;
    for (int unsigned k = 1; k <= 7; k++) begin
      prod = (term * x2) >> 30;
      unique case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (k[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 15'h7fff : v[AMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stbg_if.sv =====
// Request and result channel interfaces of the tone burst generator.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface stbg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface stbg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stbg_ctrl.sv =====
// Sequencer of the tone burst generator: steps one request through the datapath.
// Depends on stbg_pkg and the assertion macro header.
`default_nettype none
`include "sine_tone_burst_generator_core_defines.svh"

module stbg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire stbg_pkg::stbg_sts_t  sts_i,
  output stbg_pkg::stbg_cmd_t       cmd_o
);
  import stbg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_MULA,
    S_MULE,
    S_DONE
  } state_e;

  state_e               state_q;
  logic                 rdy_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = in_valid_i && rdy_q;
    cmd_o.setup    = (state_q == S_SETUP);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.mul_amp  = (state_q == S_MULA);
    cmd_o.mul_env  = (state_q == S_MULE);
    cmd_o.finish   = (state_q == S_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && rdy_q) begin
            state_q <= S_SETUP;
            rdy_q   <= 1'b0;
          end
        end
        S_SETUP: begin
          cnt_q   <= '0;
          state_q <= sts_i.div_needed ? S_DIV : S_MULA;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_MULA;
          end
        end
        S_MULA: state_q <= S_MULE;
        S_MULE: state_q <= S_DONE;
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

  `STBG_ASSERT_IMP(a_ready_only_idle, rdy_q, state_q == S_IDLE)
  `STBG_ASSERT_NXT(a_div_exit, state_q == S_DIV, state_q == S_DIV || state_q == S_MULA)
  `STBG_ASSERT_NXT(a_done_free, state_q == S_DONE && sts_i.out_free, rdy_q)

endmodule

`default_nettype wire

// ===== hw/rtl/stbg_dp.sv =====
// Datapath of the tone burst generator: registers, phase and index state, sine
// table, serial envelope divider, scaling multipliers and output register.
// Depends on stbg_pkg and the assertion macro header.
`default_nettype none
`include "sine_tone_burst_generator_core_defines.svh"

module stbg_dp #(
  parameter int unsigned SINE_ADDR_BITS = stbg_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS     = stbg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [stbg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [stbg_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire logic                                restart_i,
  input  wire stbg_pkg::stbg_cmd_t                 cmd_i,
  output stbg_pkg::stbg_sts_t                      sts_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [stbg_pkg::SMP_W-1:0]        out_sample_o,
  output logic                                     out_last_o
);
  import stbg_pkg::*;

  localparam int unsigned QA_W   = SINE_ADDR_BITS - 1;           // quarter table address
  localparam int unsigned QDEPTH = (1 << (SINE_ADDR_BITS - 2)) + 1;
  localparam int unsigned IW     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam logic [QA_W-1:0] QUARTER = QA_W'(1) << (SINE_ADDR_BITS - 2);
  localparam int unsigned PA_W   = 2 * AMP_W;
  localparam int unsigned PR_W   = PA_W + ENV_W;

  // Configuration registers
  logic [PHASE_W-1:0] step_q;
  logic [LEN_W-1:0]   burst_q;
  logic [LEN_W-1:0]   att_q;
  logic [LEN_W-1:0]   rel_q;
  logic [AMP_W-1:0]   amp_q;

  // Generator state
  logic [COUNT_BITS-1:0] idx_q;
  logic [PHASE_W-1:0]    ph_q;
  logic [COUNT_BITS-1:0] cur_i_q;
  logic [PHASE_W-1:0]    cur_ph_q;

  // Work registers
  logic [AMP_W-1:0] rom_q;
  logic             neg_q;
  logic             last_q;
  logic [LEN_W-1:0] den_q;
  logic [LEN_W-1:0] rem_q;
  logic [ENV_W-1:0] quo_q;
  logic [PA_W-1:0]  pa_q;
  logic [PR_W-1:0]  prod_q;

  logic                    out_vld_q;
  logic signed [SMP_W-1:0] sample_q;
  logic                    olast_q;

  // Sine quarter table, constant at elaboration
  logic [AMP_W-1:0] rom_tbl [QDEPTH];
  for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
    assign rom_tbl[g] = quarter_sine(SINE_ADDR_BITS, g);
  end

  // Setup-cycle decode
  logic [SINE_ADDR_BITS-1:0] ph_top;
  logic [QA_W-1:0]           r_ext;
  logic [QA_W-1:0]           rom_addr;
  logic [LEN_W-1:0]          n16;
  logic [IW-1:0]             i_ext;
  logic [IW-1:0]             n_ext;
  logic                      past_end;
  logic                      in_att;
  logic                      in_rel;
  logic                      last_w;
  logic [LEN_W-1:0]          num;
  logic [LEN_W-1:0]          den;
  logic                      ge0;
  logic [LEN_W:0]            rem2;
  logic                      ge2;
  logic [PR_W:0]             rnd;
  logic [PR_W-31:0]          magw;
  logic [AMP_W-1:0]          mag15;

  always_comb begin
    ph_top   = cur_ph_q[PHASE_W-1 -: SINE_ADDR_BITS];
    r_ext    = {1'b0, ph_top[SINE_ADDR_BITS-3:0]};
    rom_addr = ph_top[SINE_ADDR_BITS-2] ? (QUARTER - r_ext) : r_ext;

    n16      = (burst_q == '0) ? LEN_W'(1) : burst_q;
    i_ext    = IW'(cur_i_q);
    n_ext    = IW'(n16);
    past_end = (i_ext >= n_ext);
    in_att   = (att_q != '0) && (i_ext < IW'(att_q));
    in_rel   = (rel_q != '0) &&
               (({1'b0, i_ext} + (IW + 1)'(rel_q)) >= {1'b0, n_ext});
    last_w   = (({1'b0, i_ext} + (IW + 1)'(1)) >= {1'b0, n_ext}) ||
               (cur_i_q == '1);

    // Attack: i/attack, release: (n-i)/release; both numerators fit 16 bits
    if (in_att) begin
      num = i_ext[LEN_W-1:0];
      den = att_q;
    end else begin
      num = n16 - i_ext[LEN_W-1:0];
      den = rel_q;
    end
    ge0 = (num >= den);

    rem2 = {rem_q, 1'b0};
    ge2  = (rem2 >= {1'b0, den_q});

    rnd   = {1'b0, prod_q} + ((PR_W + 1)'(1) << 30);
    magw  = rnd[PR_W:31];
    mag15 = (magw > (PR_W - 30)'(32767)) ? 15'h7fff : magw[AMP_W-1:0];

    sts_o.div_needed = !past_end && (in_att || in_rel);
    sts_o.out_free   = !out_vld_q || out_ready_i;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= PHASE_STEP_RST;
      burst_q <= BURST_LEN_RST;
      att_q   <= ATTACK_LEN_RST;
      rel_q   <= RELEASE_LEN_RST;
      amp_q   <= AMPLITUDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_STEP:  step_q  <= cfg_wdata_i;
        CFG_BURST_LEN:   burst_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_ATTACK_LEN:  att_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_RELEASE_LEN: rel_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_AMPLITUDE:   amp_q   <= cfg_wdata_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample index and phase accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ph_q  <= '0;
    end else if (cmd_i.setup) begin
      idx_q <= last_w ? '0 : cur_i_q + 1'b1;
      ph_q  <= last_w ? '0 : cur_ph_q + step_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_i_q  <= restart_i ? '0 : idx_q;
      cur_ph_q <= restart_i ? '0 : ph_q;
    end
    if (cmd_i.setup) begin
      rom_q  <= rom_tbl[rom_addr];
      neg_q  <= ph_top[SINE_ADDR_BITS-1];
      last_q <= last_w;
      den_q  <= den;
      priority if (past_end) begin
        quo_q <= '0;
      end else if (in_att || in_rel) begin
        quo_q <= {{(ENV_W - 1){1'b0}}, ge0};
        rem_q <= ge0 ? num - den : num;
      end else begin
        quo_q <= ENV_W'(1) << (ENV_W - 1);
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= ge2 ? LEN_W'(rem2 - {1'b0, den_q}) : rem2[LEN_W-1:0];
      quo_q <= {quo_q[ENV_W-2:0], ge2};
    end
    if (cmd_i.mul_amp) begin
      pa_q <= PA_W'(rom_q) * PA_W'(amp_q);
    end
    if (cmd_i.mul_env) begin
      prod_q <= PR_W'(pa_q) * PR_W'(quo_q);
    end
    if (cmd_i.finish) begin
      sample_q <= neg_q ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});
      olast_q  <= last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sample_o = sample_q;
  assign out_last_o   = olast_q;

  `STBG_ASSERT_NXT(a_last_wraps, cmd_i.setup && last_w, idx_q == '0 && ph_q == '0)
  `STBG_ASSERT_IMP(a_sample_range, out_vld_q, sample_q != 16'sh8000)
  `STBG_ASSERT_IMP(a_no_overwrite, cmd_i.finish, !out_vld_q || out_ready_i)

endmodule

`default_nettype wire

// ===== hw/rtl/sine_tone_burst_generator_core.sv =====
// Top level of the sine tone burst generator: sequencer plus datapath.
// Depends on stbg_pkg, stbg_in_if/stbg_out_if, stbg_ctrl and stbg_dp.
//
// Usage
//   Each request on in_ch (restart bit) yields exactly one result on out_ch:
//   a signed 16-bit sample and a last flag marking the end of a burst. With
//   restart high the request produces sample zero of a new burst.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i with the
//   block idle; index 0 phase step, 1 burst length, 2 attack, 3 release,
//   4 amplitude. Other indexes are ignored.
// Timing
//   One request at a time: the next request is taken only once the result has
//   gone into the output register. In the attack or release the envelope comes
//   from a restoring divider, one quotient bit per cycle; in the flat or silent
//   part the divider is skipped. The divider sets the rate.
// Reset and stall
//   Reset restores register defaults and clears the sample index, phase and
//   output valid flag. A finished sample sits in the output register while the
//   next request is accepted and computed; only the final load of a second
//   result waits for out_ch.ready.
`default_nettype none

module sine_tone_burst_generator_core #(
  parameter int unsigned SINE_ADDR_BITS = stbg_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned COUNT_BITS     = stbg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [stbg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [stbg_pkg::CFG_W-1:0]     cfg_wdata_i,
  stbg_in_if.sink                             in_ch,
  stbg_out_if.source                          out_ch
);
  import stbg_pkg::*;

  stbg_cmd_t cmd;   // sequencer -> datapath
  stbg_sts_t sts;   // datapath -> sequencer

  // Sequencer owns the request handshake
  stbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath owns registers, state and the result register
  stbg_dp #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .restart_i    (in_ch.restart),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_sample_o (out_ch.sample),
    .out_last_o   (out_ch.last)
  );

endmodule

`default_nettype wire

// ===== sim/stbg_tone_checker.sv =====
// Scoreboard for the tone burst generator: snoops the register port and both channels,
// predicts each sample and last flag, and compares them in order.
// Depends on stbg_pkg and the stbg_in_if / stbg_out_if interfaces.
`timescale 1ns / 1ps

module stbg_tone_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stbg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stbg_pkg::CFG_W-1:0]     cfg_wdata_i,
  stbg_in_if                             req_ch,
  stbg_out_if                            res_ch,
  output int                             mismatch_count_o,
  output int                             samples_owed_o
);
  import stbg_pkg::*;

  localparam int unsigned TBL_BITS = SINE_ADDR_BITS_DEF;
  localparam int unsigned QTR      = 1 << (TBL_BITS - 2);
  localparam int unsigned IDX_FULL = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned MAG_MAX  = 32767;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last;
  } tone_sample_t;

  logic [AMP_W-1:0]   quarter_mag [0:QTR];
  logic [PHASE_W-1:0] step_r;
  logic [LEN_W-1:0]   burst_r;
  logic [LEN_W-1:0]   attack_r;
  logic [LEN_W-1:0]   rel_len_r;
  logic [AMP_W-1:0]   amp_r;
  logic [LEN_W-1:0]   index_r;
  logic [PHASE_W-1:0] phase_r;
  tone_sample_t       owed_q [$];
  int                 mismatches;
  int                 results_seen;

  assign mismatch_count_o = mismatches;

  // Quarter-wave magnitude: Q2.30 angle, odd Taylor terms up to x^15.
  function automatic logic [AMP_W-1:0] sine_quarter_mag(int unsigned r);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned tm;
    longint unsigned acc;
    longint unsigned scaled;
    ang    = (64'(r) * TWO_PI_Q30 + (64'd1 << (TBL_BITS - 1))) >> TBL_BITS;
    ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
    tm     = ang;
    acc    = ang;
    for (int k = 1; k <= 7; k++) begin
      tm = ((tm * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = (acc >= tm) ? acc - tm : 64'd0;
      end else begin
        acc = acc + tm;
      end
    end
    scaled = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return (scaled > MAG_MAX) ? AMP_W'(MAG_MAX) : scaled[AMP_W-1:0];
  endfunction

  initial begin
    for (int r = 0; r <= QTR; r++) quarter_mag[r] = sine_quarter_mag(r);
  end

  // One sample of the burst; advances index and phase.
  function automatic tone_sample_t next_tone_sample(logic restart);
    int unsigned     n;
    int unsigned     i;
    int unsigned     off;
    longint unsigned env;
    longint unsigned mag;
    logic [1:0]      quad;
    tone_sample_t    res;
    n = (burst_r == '0) ? 1 : burst_r;
    if (restart) begin
      index_r = '0;
      phase_r = '0;
    end
    i = index_r;
    if (i >= n) begin
      env = 0;
    end else if (attack_r != '0 && i < attack_r) begin
      env = (64'(i) << 16) / attack_r;
    end else if (rel_len_r != '0 && i + rel_len_r >= n) begin
      env = (64'(n - i) << 16) / rel_len_r;
    end else begin
      env = 64'd65536;
    end
    quad = phase_r[PHASE_W-1 -: 2];
    off  = phase_r[PHASE_W-3 -: TBL_BITS-2];
    if (quad[0]) off = QTR - off;
    mag = (64'(quarter_mag[off]) * amp_r * env + (64'd1 << 30)) >> 31;
    if (mag > MAG_MAX) mag = MAG_MAX;
    res.sample = quad[1] ? SMP_W'(64'd0 - mag) : SMP_W'(mag);
    res.last   = (i + 1 >= n) || (i == IDX_FULL);
    if (res.last) begin
      index_r = '0;
      phase_r = '0;
    end else begin
      index_r = LEN_W'(i + 1);
      phase_r = phase_r + step_r;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    if (mismatches < 40) begin
      $display("stbg check: result %0d %s: expected %0d, got %0d",
               results_seen, what, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tone_sample_t want;
    if (!rst_ni) begin
      step_r    = PHASE_STEP_RST;
      burst_r   = BURST_LEN_RST;
      attack_r  = ATTACK_LEN_RST;
      rel_len_r = RELEASE_LEN_RST;
      amp_r     = AMPLITUDE_RST;
      index_r   = '0;
      phase_r   = '0;
      owed_q.delete();
      samples_owed_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHASE_STEP:  step_r    = cfg_wdata_i;
          CFG_BURST_LEN:   burst_r   = cfg_wdata_i[LEN_W-1:0];
          CFG_ATTACK_LEN:  attack_r  = cfg_wdata_i[LEN_W-1:0];
          CFG_RELEASE_LEN: rel_len_r = cfg_wdata_i[LEN_W-1:0];
          CFG_AMPLITUDE:   amp_r     = cfg_wdata_i[AMP_W-1:0];
          default: ;
        endcase
      end
      // retire first so a stray result never pairs with a request of this edge
      if (res_ch.valid && res_ch.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("with no request", 0, int'($signed(res_ch.sample)));
        end else begin
          want = owed_q.pop_front();
          if (res_ch.sample !== want.sample) begin
            report_mismatch("sample", int'($signed(want.sample)),
                            int'($signed(res_ch.sample)));
          end
          if (res_ch.last !== want.last) begin
            report_mismatch("last", int'(want.last), int'(res_ch.last));
          end
        end
        results_seen++;
      end
      if (req_ch.valid && req_ch.ready) begin
        owed_q.insert(owed_q.size(), next_tone_sample(req_ch.restart));
      end
      samples_owed_o <= owed_q.size();
    end
  end

endmodule

// ===== sim/sine_tone_burst_generator_core_tb.sv =====
// Stimulus and verdict for the sine tone burst generator core.
// Depends on stbg_pkg, stbg_in_if / stbg_out_if, the core and stbg_tone_checker.
`timescale 1ns / 1ps

module sine_tone_burst_generator_core_tb;
  import stbg_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int IDX_SPAN     = 1 << CFG_IDX_W;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  int                   mismatch_count;
  int                   samples_owed;
  int                   requests_sent;
  // phases with no idling on either side
  bit                   steady_flow;

  stbg_in_if  req_ch ();
  stbg_out_if res_ch ();

  sine_tone_burst_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (req_ch),
    .out_ch      (res_ch)
  );

  stbg_tone_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_ch           (req_ch),
    .res_ch           (res_ch),
    .mismatch_count_o (mismatch_count),
    .samples_owed_o   (samples_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one so gaps land on every step of the divider sequence.
  function automatic int flow_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure. Every assignment sits in its own time step.
  initial begin
    int hold;
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = flow_gap();
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Register write: one cycle with the enable high, one with it low, so that
  // back-to-back writes never drop and raise the enable in the same step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // All five registers; the narrow ones sometimes carry junk above their width.
  task automatic write_tone_setup(logic [PHASE_W-1:0] step, logic [LEN_W-1:0] burst,
                                  logic [LEN_W-1:0] attack, logic [LEN_W-1:0] rel_len,
                                  logic [AMP_W-1:0] amp);
    logic [CFG_W-1:0] junk;
    junk = $urandom_range(0, 1) ? CFG_W'($urandom) : '0;
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_BURST_LEN, {junk[CFG_W-1:LEN_W], burst});
    write_reg(CFG_ATTACK_LEN, {junk[CFG_W-1:LEN_W], attack});
    write_reg(CFG_RELEASE_LEN, {junk[CFG_W-1:LEN_W], rel_len});
    write_reg(CFG_AMPLITUDE, {junk[CFG_W-1:AMP_W], amp});
  endtask

  // One request; valid stays high on return so the next request can follow
  // without a bubble.
  task automatic send_request(logic restart);
    int gap;
    gap = flow_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop requesting and wait for every owed sample. The first edge lets the
  // checker's count catch up with a request accepted on the edge just past.
  task automatic drain_samples();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (samples_owed != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int                 burst;
    int                 attack;
    int                 rel_len;
    int                 kind;
    int                 count;
    int                 restart_pct;
    int                 phase_no;
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0]   amp;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_PHASE_STEP;
    cfg_wdata_i    <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    steady_flow    = 1'b0;
    requests_sent  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: sample zero is silent, then the attack ramp begins.
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_samples();

    // Quarter-turn steps hit every quadrant boundary at full amplitude, with
    // attack and release both skipped; the fifth request wraps the burst.
    write_tone_setup(32'h4000_0000, 16'd4, 16'd0, 16'd0, 15'h7fff);
    repeat (5) send_request(1'b0);
    drain_samples();

    // Zero burst length behaves as one (every sample last); amplitude goes to
    // zero through a write whose bits above the register are all ones.
    write_reg(CFG_BURST_LEN, 32'habcd_0000);
    write_reg(CFG_PHASE_STEP, '1);
    write_reg(CFG_AMPLITUDE, 32'hffff_8000);
    send_request(1'b0);
    send_request(1'b1);
    drain_samples();

    // Longest burst, short ramps; unused register indexes must be ignored.
    write_tone_setup(32'h0123_4567, 16'hffff, 16'd3, 16'd2, 15'h7fff);
    for (int idx = CFG_AMPLITUDE + 1; idx < IDX_SPAN; idx++) begin
      write_reg(CFG_IDX_W'(idx), CFG_W'($urandom));
    end
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    drain_samples();

    // Burst shortened under the running index: silent last sample, then wrap.
    write_reg(CFG_BURST_LEN, 32'd3);
    repeat (2) send_request(1'b0);
    drain_samples();

    // Random phases: mostly short bursts so attack, flat part, release and
    // the wrap all come round many times; some noise with frequent restarts.
    phase_no = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      kind        = $urandom_range(0, 9);
      steady_flow = ($urandom_range(0, 4) == 0);
      restart_pct = 3;
      step        = $urandom;
      amp         = AMP_W'($urandom);
      burst       = $urandom_range(1, 40);
      attack      = $urandom_range(0, burst + 4);
      rel_len     = $urandom_range(0, burst + 4);
      case (kind)
        0: begin
          // corners of every register
          case ($urandom_range(0, 3))
            0: burst = 0;
            1: burst = 1;
            2: burst = 2;
            default: burst = 65535;
          endcase
          case ($urandom_range(0, 2))
            0: attack = 0;
            1: attack = 1;
            default: attack = 65535;
          endcase
          case ($urandom_range(0, 2))
            0: rel_len = 0;
            1: rel_len = 1;
            default: rel_len = 65535;
          endcase
          amp = $urandom_range(0, 1) ? '1 : '0;
          case ($urandom_range(0, 2))
            0: step = '0;
            1: step = '1;
            default: ;
          endcase
        end
        1: begin
          // longer bursts at audio-like rates
          burst   = $urandom_range(150, 400);
          attack  = $urandom_range(0, 200);
          rel_len = $urandom_range(0, 200);
          step    = $urandom_range(0, 1 << 26);
        end
        2: restart_pct = 40;
        default: ;
      endcase
      write_tone_setup(step, LEN_W'(burst), LEN_W'(attack), LEN_W'(rel_len), amp);

      count = $urandom_range(40, 110);
      for (int k = 0; k < count; k++) begin
        // now and then hold off mid-phase until every sample is back
        if (k == count / 2 && phase_no % 5 == 2) drain_samples();
        send_request($urandom_range(0, 99) < restart_pct);
      end
      drain_samples();
      phase_no++;
    end

    steady_flow = 1'b0;
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && samples_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
